>>> design/msb_first_bit_reader_unit_assert.svh
// Assertion macros for the MSB-first bit reader.
`ifndef MSB_FIRST_BIT_READER_UNIT_ASSERT_SVH
`define MSB_FIRST_BIT_READER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> design/mbr_pkg.sv
// Package: shared types and constants of the MSB-first bit reader.
`default_nettype none
package mbr_pkg;

  // Store depth is a power of two; the read position wraps naturally.
  localparam int SRC_DEPTH     = 256;
  localparam int SRC_AW        = $clog2(SRC_DEPTH);
  localparam int MAX_READ_BITS = 64;
  localparam int CNT_W         = $clog2(MAX_READ_BITS + 1);
  localparam int BYTE_BITS     = 8;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_READ,
    OP_RESTART,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SRC_AW-1:0] addr;
    logic [7:0]        data;
    logic [CNT_W-1:0]  nbits;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

>>> design/mbr_front.sv
// Front end: accepts input beats and classifies them into queue commands.
`default_nettype none
module mbr_front (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_kind,
  input  wire logic [7:0]       in_load_address,
  input  wire logic [7:0]       in_load_byte,
  input  wire logic [6:0]       in_bit_count,
  input  wire logic             q_ready,
  output logic                  q_push,
  output mbr_pkg::cmd_t         q_cmd
);

  logic known;

  always_comb begin
    known        = 1'b1;
    q_cmd.addr   = mbr_pkg::SRC_AW'(32'(in_load_address) % mbr_pkg::SRC_DEPTH);
    q_cmd.data   = in_load_byte;
    q_cmd.nbits  = (32'(in_bit_count) > mbr_pkg::MAX_READ_BITS)
                   ? mbr_pkg::CNT_W'(mbr_pkg::MAX_READ_BITS)
                   : mbr_pkg::CNT_W'(in_bit_count);
    q_cmd.op     = mbr_pkg::OP_LOAD;
    case (in_kind)
      mbr_pkg::KIND_LOAD:    q_cmd.op = mbr_pkg::OP_LOAD;
      mbr_pkg::KIND_READ: begin
        q_cmd.op = (in_bit_count == 7'd0) ? mbr_pkg::OP_ZERO : mbr_pkg::OP_READ;
      end
      mbr_pkg::KIND_RESTART: q_cmd.op = mbr_pkg::OP_RESTART;
      default:               known = 1'b0;
    endcase
  end

  // unused kind is taken and dropped
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && known;

endmodule
`default_nettype wire

>>> design/mbr_queue.sv
// Command queue between front and back ends.
`default_nettype none
module mbr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mbr_pkg::cmd_t  push_cmd,
  output logic                ready,
  input  wire logic           pop,
  output logic                valid,
  output mbr_pkg::cmd_t       head
);

  mbr_pkg::cmd_t            slot_r [mbr_pkg::Q_DEPTH];
  logic [mbr_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mbr_pkg::Q_AW:0]   count_r, count_nxt;
  logic                     do_push, do_pop;

  assign ready   = count_r != (mbr_pkg::Q_AW + 1)'(mbr_pkg::Q_DEPTH);
  assign valid   = count_r != '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> design/mbr_back.sv
// Back end: byte store, bit extraction sequencer and output register.
`default_nettype none
module mbr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire mbr_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [3:0]          out_bytes_fetched
);

  logic [7:0] src_mem [mbr_pkg::SRC_DEPTH];
  logic [7:0] rd_data_r;

  mbr_pkg::back_state_t state_r, state_nxt;

  logic [mbr_pkg::SRC_AW-1:0] pos_r, pos_nxt, mem_ra;
  logic [7:0]                 held_r, held_nxt;
  logic [2:0]                 held_cnt_r, held_cnt_nxt;
  logic [mbr_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic [3:0]                 fetched_r, fetched_nxt, fetched_inc;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, res_byte;
  logic                       out_last_r, res_last;
  logic [3:0]                 out_fetched_r, res_fetched;
  logic                       mem_we, mem_re, produce, out_free;
  logic [3:0]                 w, need;
  logic                       is_last, from_held;
  logic [7:0]                 hi_part, lo_part;

  assign out_free    = !out_valid_r || out_ready;
  assign w           = (left_r >= mbr_pkg::CNT_W'(mbr_pkg::BYTE_BITS)) ? 4'd8
                       : {1'b0, left_r[2:0]};
  assign is_last     = left_r <= mbr_pkg::CNT_W'(mbr_pkg::BYTE_BITS);
  assign from_held   = {1'b0, held_cnt_r} >= w;
  assign need        = w - {1'b0, held_cnt_r};
  assign hi_part     = held_r >> (4'd8 - w);
  assign lo_part     = rd_data_r >> (4'd8 - need);
  assign fetched_inc = (fetched_r == 4'hF) ? fetched_r : fetched_r + 4'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbr_pkg::ST_IDLE: begin
        if (q_valid && q_cmd.op == mbr_pkg::OP_READ) begin
          state_nxt = mbr_pkg::ST_EMIT;
        end
      end
      mbr_pkg::ST_EMIT: begin
        if (out_free && is_last) begin
          state_nxt = mbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = pos_r;
    pos_nxt      = pos_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    left_nxt     = left_r;
    fetched_nxt  = fetched_r;
    produce      = 1'b0;
    res_byte     = '0;
    res_last     = 1'b0;
    res_fetched  = '0;
    case (state_r)
      mbr_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            mbr_pkg::OP_LOAD: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            mbr_pkg::OP_RESTART: begin
              q_pop        = 1'b1;
              pos_nxt      = '0;
              held_nxt     = '0;
              held_cnt_nxt = '0;
            end
            mbr_pkg::OP_ZERO: begin
              if (out_free) begin
                q_pop    = 1'b1;
                produce  = 1'b1;
                res_last = 1'b1;
              end
            end
            mbr_pkg::OP_READ: begin
              q_pop       = 1'b1;
              mem_re      = 1'b1;
              left_nxt    = q_cmd.nbits;
              fetched_nxt = '0;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      mbr_pkg::ST_EMIT: begin
        if (out_free) begin
          produce  = 1'b1;
          left_nxt = left_r - mbr_pkg::CNT_W'(w);
          if (from_held) begin
            res_byte     = hi_part;
            held_nxt     = 8'(held_r << w);
            held_cnt_nxt = held_cnt_r - w[2:0];
          end else begin
            // consume prefetched byte and prefetch the one after it
            res_byte     = hi_part | lo_part;
            held_nxt     = 8'(rd_data_r << need);
            held_cnt_nxt = 3'(4'd8 - need);
            pos_nxt      = pos_r + 1'b1;
            fetched_nxt  = fetched_inc;
            mem_re       = 1'b1;
            mem_ra       = pos_r + 1'b1;
          end
          res_last    = is_last;
          res_fetched = is_last ? fetched_nxt : 4'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = produce || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbr_pkg::ST_IDLE;
      pos_r       <= '0;
      held_r      <= '0;
      held_cnt_r  <= '0;
      left_r      <= '0;
      fetched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      held_cnt_r  <= held_cnt_nxt;
      left_r      <= left_nxt;
      fetched_r   <= fetched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_byte_r    <= res_byte;
      out_last_r    <= res_last;
      out_fetched_r <= res_fetched;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      src_mem[q_cmd.addr] <= q_cmd.data;
    end
    if (mem_re) begin
      rd_data_r <= src_mem[mem_ra];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last          = out_last_r;
  assign out_bytes_fetched = out_fetched_r;

endmodule
`default_nettype wire

>>> design/msb_first_bit_reader_unit.sv
// Top level of the MSB-first bit reader.
// Reads fields of 1 to 64 bits MSB first from a 256-byte store that load beats
// fill. A front end classifies each input beat of a known kind into a 4-entry
// command queue; the back end runs one command at a time. Load, restart and
// zero-length reads are handled in the idle state; a read first primes the
// registered store read and then emits its output beats in turn, paced by the
// single store read port. Output beats leave through an output register; while
// a beat waits to be taken, reads and zero-length reads hold, and the queue takes
// input beats until its four entries are full and in_ready drops.
`default_nettype none
`include "msb_first_bit_reader_unit_assert.svh"
module msb_first_bit_reader_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_load_address,
  input  wire logic [7:0] in_load_byte,
  input  wire logic [6:0] in_bit_count,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [3:0]      out_bytes_fetched
);

  logic          q_ready, q_push, q_valid, q_pop;
  mbr_pkg::cmd_t push_cmd, head_cmd;

  mbr_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_load_address (in_load_address),
    .in_load_byte    (in_load_byte),
    .in_bit_count    (in_bit_count),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  mbr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  mbr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_bytes_fetched (out_bytes_fetched)
  );

  `MBR_ASSERT_NOW(a_pop_needs_entry, clk, rst_n, q_pop, q_valid)
  `MBR_ASSERT_NOW(a_fetched_only_on_last, clk, rst_n, out_valid && !out_last,
                  out_bytes_fetched == 4'd0)
  `MBR_ASSERT_NEXT(a_zero_read_emits_last, clk, rst_n,
                   q_pop && head_cmd.op == mbr_pkg::OP_ZERO,
                   out_valid && out_last && out_byte == 8'd0)

endmodule
`default_nettype wire
